@@ sv/tpi_pkg.sv @@
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared types, codes and widths for the trapezoid profile interpolator.
// ----------------------------------------------------------------------------
package tpi_pkg;

    localparam int unsigned AXES    = 18;
    localparam int          AXIS_AW = (AXES > 1) ? $clog2(AXES) : 1;

    // divider: quotient always below 2**DIV_QW for every division issued
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 18;
    localparam int DIV_CW = $clog2(DIV_QW + 1);

    localparam int APB_AW = 4;

    typedef logic [AXIS_AW-1:0] axis_addr_t;
    typedef logic [DIV_NW-1:0]  div_num_t;
    typedef logic [DIV_DW-1:0]  div_den_t;
    typedef logic [DIV_QW-1:0]  div_quot_t;
    typedef logic [DIV_CW-1:0]  div_cnt_t;
    typedef logic [APB_AW-1:0]  apb_addr_t;

    // Q0.16 with headroom for 1.0
    typedef logic [16:0] ratio_t;
    localparam ratio_t      RATIO_ONE = 17'h10000;
    localparam logic [17:0] RATIO_TWO = 18'h20000;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] PH_UNREADY = 2'd0;
    localparam logic [1:0] PH_READY   = 2'd1;
    localparam logic [1:0] PH_MOTION  = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [1:0] REG_DURATION = 2'd0;
    localparam logic [1:0] REG_ACCEL    = 2'd1;
    localparam logic [1:0] REG_DECEL    = 2'd2;

    localparam logic [1:0] SEG_ACCEL  = 2'd0;
    localparam logic [1:0] SEG_CRUISE = 2'd1;
    localparam logic [1:0] SEG_DECEL  = 2'd2;

    localparam logic [31:0] DURATION_RST = 32'd5000;
    localparam logic [14:0] ACCEL_RST    = 15'd26214;
    localparam logic [14:0] DECEL_RST    = 15'd26214;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         axis;
        logic signed [31:0] position;
        logic signed [31:0] end_position;
        logic [31:0]        time_tick;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] position_out;
        logic               accepted;
        logic [1:0]         phase;
    } rsp_t;

    typedef struct packed {
        logic [31:0] move_duration_ticks;
        logic [14:0] accel_fraction;
        logic [14:0] decel_fraction;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ sv/tpi_ram.sv @@
// ----------------------------------------------------------------------------
// tpi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpi_ram #(
    parameter int  WIDTH = 64,
    parameter int  DEPTH = 18,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tpi_cfg.sv @@
// ----------------------------------------------------------------------------
// tpi_cfg
// APB register file: move duration, accel and decel fractions.
// ----------------------------------------------------------------------------
module tpi_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  tpi_pkg::apb_addr_t  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tpi_pkg::cfg_t       cfg
);

    logic [31:0] duration_reg, duration_next;
    logic [14:0] accel_reg, accel_next;
    logic [14:0] decel_reg, decel_next;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[tpi_pkg::APB_AW-1:2];

    always_comb
    begin
        duration_next = duration_reg;
        accel_next    = accel_reg;
        decel_next    = decel_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                tpi_pkg::REG_DURATION: duration_next = pwdata;
                tpi_pkg::REG_ACCEL:    accel_next    = pwdata[14:0];
                tpi_pkg::REG_DECEL:    decel_next    = pwdata[14:0];
                default:               duration_next = duration_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            tpi_pkg::REG_DURATION: prdata = duration_reg;
            tpi_pkg::REG_ACCEL:    prdata = {17'd0, accel_reg};
            tpi_pkg::REG_DECEL:    prdata = {17'd0, decel_reg};
            default:               prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= tpi_pkg::DURATION_RST;
            accel_reg    <= tpi_pkg::ACCEL_RST;
            decel_reg    <= tpi_pkg::DECEL_RST;
        end
        else
        begin
            duration_reg <= duration_next;
            accel_reg    <= accel_next;
            decel_reg    <= decel_next;
        end
    end

    assign cfg.move_duration_ticks = duration_reg;
    assign cfg.accel_fraction      = accel_reg;
    assign cfg.decel_fraction      = decel_reg;

endmodule

@@ sv/tpi_div.sv @@
// ----------------------------------------------------------------------------
// tpi_div
// Restoring divider, one quotient bit per cycle. Caller keeps num < den << QW.
// ----------------------------------------------------------------------------
module tpi_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tpi_pkg::div_num_t   num,
    input  tpi_pkg::div_den_t   den,
    output tpi_pkg::div_quot_t  quot,
    output tpi_pkg::div_stat_t  stat
);

    localparam int DW = tpi_pkg::DIV_DW;
    localparam int QW = tpi_pkg::DIV_QW;
    localparam int NW = tpi_pkg::DIV_NW;

    tpi_pkg::div_den_t  rem_reg, rem_next;
    tpi_pkg::div_den_t  den_reg, den_next;
    tpi_pkg::div_quot_t lo_reg, lo_next;
    tpi_pkg::div_quot_t quot_reg, quot_next;
    tpi_pkg::div_cnt_t  cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DW:0] trial;
    logic [DW:0] trial_diff;
    logic        trial_ge;

    assign trial      = {rem_reg, lo_reg[QW-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign trial_ge   = (trial >= {1'b0, den_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        lo_next   = lo_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = tpi_pkg::div_den_t'(num[NW-1:QW]);
            lo_next   = num[QW-1:0];
            den_next  = den;
            quot_next = '0;
            cnt_next  = tpi_pkg::div_cnt_t'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
            lo_next   = {lo_reg[QW-2:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], trial_ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == tpi_pkg::div_cnt_t'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        lo_reg   <= lo_next;
        quot_reg <= quot_next;
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sv/trapezoid_profile_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// trapezoid_profile_interpolator_top
// Point-to-point trapezoidal velocity profile interpolator for a set of axes.
//
// cmd channel (cmd_valid/cmd_stall/cmd) carries load, start and tick
// transactions; rsp channel (rsp_valid/rsp_stall/rsp) returns one result per
// transaction. Begin/end positions live in one axis RAM (whole-entry write,
// registered read); an APB port holds duration and segment fractions.
// One transaction is worked on at a time. Load, start and no-op go straight
// to the final state, a tick outside motion adds the elapsed-time step, and a
// tick in motion makes up to two passes through the shared restoring divider
// (time ratio, then profile ratio) plus the multiply and rounding steps. A tick
// past the end of the move skips the first pass.
// A finished result sits in the rsp register; the next transaction is taken
// while it waits. When rsp_stall is high the result holds and the block
// stalls cmd only once a second result is ready.
// Reset: phase unready, start tick 0, registers to defaults, rsp empty.
// Axis RAM contents are not cleared; axes must be loaded before use.
// ----------------------------------------------------------------------------
module trapezoid_profile_interpolator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  tpi_pkg::cmd_t       cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output tpi_pkg::rsp_t       rsp,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  tpi_pkg::apb_addr_t  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_ELAPSED = 10'b0000000010,
        ST_CHECK   = 10'b0000000100,
        ST_DIV_T   = 10'b0000001000,
        ST_PMUL    = 10'b0000010000,
        ST_PGO     = 10'b0000100000,
        ST_DIV_P   = 10'b0001000000,
        ST_BLEND   = 10'b0010000000,
        ST_ROUND   = 10'b0100000000,
        ST_FINAL   = 10'b1000000000
    } state_t;

    tpi_pkg::cfg_t cfg;

    tpi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // control state
    state_t              state_reg, state_next;
    logic [1:0]          phase_reg, phase_next;
    logic [31:0]         start_reg, start_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // transaction and datapath
    logic [1:0]          kind_reg, kind_next;
    logic                ok_reg, ok_next;
    logic signed [31:0]  pos_reg, pos_next;
    logic [31:0]         time_reg, time_next;
    logic                acc_reg, acc_next;
    logic                blend_reg, blend_next;
    logic [31:0]         el_reg, el_next;
    tpi_pkg::ratio_t     t_reg, t_next;
    logic [1:0]          seg_reg, seg_next;
    logic [29:0]         base_reg, base_next;
    tpi_pkg::div_den_t   den_reg, den_next;
    logic                zd_reg, zd_next;
    tpi_pkg::ratio_t     p_reg, p_next;
    logic signed [50:0]  prod_reg, prod_next;
    logic [31:0]         rnd_reg, rnd_next;
    tpi_pkg::rsp_t       rsp_reg, rsp_next;

    logic                cmd_accept;
    logic                ok_in;

    // axis RAM: {begin, end}
    logic                ram_we;
    logic                ram_re;
    logic [63:0]         ram_rdata;
    logic signed [31:0]  begin_pos;
    logic signed [31:0]  end_pos;

    // divider
    logic                div_start;
    tpi_pkg::div_num_t   div_num;
    tpi_pkg::div_den_t   div_den;
    tpi_pkg::div_quot_t  div_quot;
    tpi_pkg::div_stat_t  div_stat;

    // profile arithmetic
    logic [32:0]         el_diff;
    logic [31:0]         dur_eff;
    logic [17:0]         q_val;
    tpi_pkg::ratio_t     cruise_end;
    tpi_pkg::ratio_t     u_val;
    logic                seg1;
    logic                seg2;
    logic [14:0]         sq_op;
    logic [29:0]         sq;
    logic [17:0]         lin;
    logic [14:0]         frac_sel;
    logic [32:0]         den_mul;
    tpi_pkg::div_quot_t  quot_one;
    logic signed [32:0]  span;
    logic signed [50:0]  prod_w;
    logic signed [50:0]  rnd_sum;
    logic signed [31:0]  pos_sel;

    assign cmd_stall  = (state_reg != ST_IDLE);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign ok_in      = (32'(cmd.axis) < tpi_pkg::AXES);

    assign ram_we = cmd_accept && (cmd.kind == tpi_pkg::KIND_LOAD)
                    && (phase_reg != tpi_pkg::PH_MOTION) && ok_in;
    assign ram_re = cmd_accept && (cmd.kind == tpi_pkg::KIND_TICK);

    tpi_ram #(
        .WIDTH (64),
        .DEPTH (tpi_pkg::AXES)
    ) u_axis_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tpi_pkg::axis_addr_t'(cmd.axis)),
        .wdata ({cmd.position, cmd.end_position}),
        .re    (ram_re),
        .raddr (tpi_pkg::axis_addr_t'(cmd.axis)),
        .rdata (ram_rdata)
    );

    assign begin_pos = ram_rdata[63:32];
    assign end_pos   = ram_rdata[31:0];

    tpi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_quot),
        .stat  (div_stat)
    );

    assign el_diff    = {1'b0, time_reg} - {1'b0, start_reg};
    assign dur_eff    = (cfg.move_duration_ticks == 32'd0) ? 32'd1 : cfg.move_duration_ticks;
    assign q_val      = tpi_pkg::RATIO_TWO - {3'd0, cfg.accel_fraction}
                        - {3'd0, cfg.decel_fraction};
    assign cruise_end = tpi_pkg::RATIO_ONE - {2'd0, cfg.decel_fraction};
    assign u_val      = tpi_pkg::RATIO_ONE - t_reg;
    assign seg1       = (t_reg < {2'd0, cfg.accel_fraction});
    assign seg2       = !seg1 && (t_reg < cruise_end);
    assign sq_op      = seg1 ? t_reg[14:0] : u_val[14:0];
    assign sq         = 30'(sq_op) * 30'(sq_op);
    assign lin        = {t_reg, 1'b0} - {3'd0, cfg.accel_fraction};
    assign frac_sel   = seg1 ? cfg.accel_fraction : cfg.decel_fraction;
    assign den_mul    = 33'(frac_sel) * 33'(q_val);
    assign quot_one   = tpi_pkg::div_quot_t'(tpi_pkg::RATIO_ONE);

    assign span    = {end_pos[31], end_pos} - {begin_pos[31], begin_pos};
    assign prod_w  = $signed({1'b0, p_reg}) * span;
    assign rnd_sum = prod_reg + 51'sd32768;

    always_comb
    begin
        if (kind_reg != tpi_pkg::KIND_TICK)
        begin
            pos_sel = 32'sd0;
        end
        else if (!ok_reg || (phase_reg == tpi_pkg::PH_UNREADY))
        begin
            pos_sel = pos_reg;
        end
        else if (phase_reg == tpi_pkg::PH_READY)
        begin
            pos_sel = begin_pos;
        end
        else if (blend_reg)
        begin
            pos_sel = begin_pos + rnd_reg;
        end
        else
        begin
            pos_sel = end_pos;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = start_reg;
        rsp_valid_next = rsp_valid_reg;
        kind_next      = kind_reg;
        ok_next        = ok_reg;
        pos_next       = pos_reg;
        time_next      = time_reg;
        acc_next       = acc_reg;
        blend_next     = blend_reg;
        el_next        = el_reg;
        t_next         = t_reg;
        seg_next       = seg_reg;
        base_next      = base_reg;
        den_next       = den_reg;
        zd_next        = zd_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        rnd_next       = rnd_reg;
        rsp_next       = rsp_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    kind_next  = cmd.kind;
                    ok_next    = ok_in;
                    pos_next   = cmd.position;
                    time_next  = cmd.time_tick;
                    acc_next   = 1'b0;
                    blend_next = 1'b0;
                    state_next = ST_FINAL;
                    unique case (cmd.kind)
                        tpi_pkg::KIND_LOAD:
                        begin
                            if ((phase_reg != tpi_pkg::PH_MOTION) && ok_in)
                            begin
                                phase_next = tpi_pkg::PH_READY;
                                acc_next   = 1'b1;
                            end
                        end
                        tpi_pkg::KIND_START:
                        begin
                            if (phase_reg == tpi_pkg::PH_READY)
                            begin
                                phase_next = tpi_pkg::PH_MOTION;
                                start_next = cmd.time_tick;
                                acc_next   = 1'b1;
                            end
                        end
                        tpi_pkg::KIND_TICK:
                        begin
                            acc_next   = 1'b1;
                            state_next = ST_ELAPSED;
                        end
                        tpi_pkg::KIND_NOP:
                        begin
                            acc_next = 1'b0;
                        end
                        default:
                        begin
                            acc_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_ELAPSED:
            begin
                el_next    = el_diff[32] ? 32'd0 : el_diff[31:0];
                state_next = (phase_reg == tpi_pkg::PH_MOTION) ? ST_CHECK : ST_FINAL;
            end
            ST_CHECK:
            begin
                if (el_reg > dur_eff)
                begin
                    phase_next = tpi_pkg::PH_DONE;
                    t_next     = tpi_pkg::RATIO_ONE;
                    state_next = ST_PMUL;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = tpi_pkg::div_num_t'({el_reg, 16'h0000});
                    div_den    = tpi_pkg::div_den_t'(dur_eff);
                    state_next = ST_DIV_T;
                end
            end
            ST_DIV_T:
            begin
                if (div_stat.done)
                begin
                    t_next     = div_quot[16:0];
                    state_next = ST_PMUL;
                end
            end
            ST_PMUL:
            begin
                seg_next   = seg1 ? tpi_pkg::SEG_ACCEL
                           : (seg2 ? tpi_pkg::SEG_CRUISE : tpi_pkg::SEG_DECEL);
                base_next  = seg2 ? 30'(lin) : sq;
                den_next   = seg2 ? tpi_pkg::div_den_t'(q_val) : tpi_pkg::div_den_t'(den_mul);
                zd_next    = !seg1 && !seg2
                             && ((u_val == '0) || (cfg.decel_fraction == 15'd0));
                state_next = ST_PGO;
            end
            ST_PGO:
            begin
                if (zd_reg)
                begin
                    p_next     = tpi_pkg::RATIO_ONE;
                    state_next = ST_BLEND;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = tpi_pkg::div_num_t'({base_reg, 16'h0000})
                                 + tpi_pkg::div_num_t'(den_reg[tpi_pkg::DIV_DW-1:1]);
                    div_den    = den_reg;
                    state_next = ST_DIV_P;
                end
            end
            ST_DIV_P:
            begin
                if (div_stat.done)
                begin
                    if (seg_reg == tpi_pkg::SEG_DECEL)
                    begin
                        p_next = (div_quot >= quot_one) ? '0
                               : (tpi_pkg::RATIO_ONE - div_quot[16:0]);
                    end
                    else
                    begin
                        p_next = (div_quot > quot_one) ? tpi_pkg::RATIO_ONE : div_quot[16:0];
                    end
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                prod_next  = prod_w;
                blend_next = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                rnd_next   = rnd_sum[47:16];
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.position_out = pos_sel;
                    rsp_next.accepted     = acc_reg;
                    rsp_next.phase        = phase_reg;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= tpi_pkg::PH_UNREADY;
            start_reg     <= 32'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        ok_reg    <= ok_next;
        pos_reg   <= pos_next;
        time_reg  <= time_next;
        acc_reg   <= acc_next;
        blend_reg <= blend_next;
        el_reg    <= el_next;
        t_reg     <= t_next;
        seg_reg   <= seg_next;
        base_reg  <= base_next;
        den_reg   <= den_next;
        zd_reg    <= zd_next;
        p_reg     <= p_next;
        prod_reg  <= prod_next;
        rnd_reg   <= rnd_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // motion only entered by a start transaction
    a_motion_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tpi_pkg::PH_MOTION && $past(phase_reg) != tpi_pkg::PH_MOTION)
        |-> $past(cmd_accept && cmd.kind == tpi_pkg::KIND_START))
        else $error("motion entered without start transaction");

    a_done_from_motion: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == tpi_pkg::PH_DONE && $past(phase_reg) != tpi_pkg::PH_DONE)
        |-> $past(phase_reg) == tpi_pkg::PH_MOTION)
        else $error("finished phase reached outside motion");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept |=> state_reg != ST_IDLE)
        else $error("transaction accepted but sequencer stayed idle");

endmodule

@@ dv/trapezoid_profile_interpolator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trapezoid_profile_interpolator_top_tb
// Drives load, start, tick and no-op transactions with random gaps and
// response stalls, and predicts every response from a local model of the
// phase logic, time ratio, trapezoid shape and position blend. Responses are
// checked field by field in order. The APB registers are rewritten between
// phases, extremes included, and read back.
// ----------------------------------------------------------------------------
module trapezoid_profile_interpolator_top_tb;

    localparam longint unsigned Q16_ONE     = 64'd65536;
    localparam logic [1:0]      REG_UNMAPPED = 2'd3;
    localparam int              CYCLE_LIMIT  = 1000000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    tpi_pkg::cmd_t        cmd       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    tpi_pkg::rsp_t        rsp;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    tpi_pkg::apb_addr_t   paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // model state
    logic [31:0]        cfg_dur = tpi_pkg::DURATION_RST;
    logic [14:0]        cfg_acc = tpi_pkg::ACCEL_RST;
    logic [14:0]        cfg_dec = tpi_pkg::DECEL_RST;
    logic [1:0]         ph      = tpi_pkg::PH_UNREADY;
    logic [31:0]        t0      = '0;
    logic signed [31:0] begin_pos [tpi_pkg::AXES];
    logic signed [31:0] end_pos   [tpi_pkg::AXES];
    bit                 loaded    [tpi_pkg::AXES];

    tpi_pkg::cmd_t pending_cmds [$];
    tpi_pkg::rsp_t setpoint_q   [$];
    tpi_pkg::rsp_t want_rsp;
    int   items_sent = 0;
    int   mismatches = 0;
    int   cycle_count = 0;
    int   feed_mode  = 1;
    int   drain_mode = 1;
    int   feed_gap   = 0;
    int   stall_left = 0;
    logic cmd_taken  = 1'b0;

    trapezoid_profile_interpolator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned div_nearest(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint unsigned eff_duration();
        return (cfg_dur == 32'd0) ? 64'd1 : longint'(cfg_dur);
    endfunction

    // time ratio to position ratio, both Q0.16
    function automatic longint unsigned shape_ratio(longint unsigned t);
        longint unsigned a, c, q, p, u, d;
        a = cfg_acc;
        c = cfg_dec;
        q = 2 * Q16_ONE - a - c;
        if (t < a)
            p = div_nearest(t * t * Q16_ONE, a * q);
        else if (t < Q16_ONE - c)
            p = div_nearest((2 * t - a) * Q16_ONE, q);
        else
        begin
            u = Q16_ONE - t;
            d = (u == 0 || c == 0) ? 64'd0 : div_nearest(u * u * Q16_ONE, c * q);
            p = (d >= Q16_ONE) ? 64'd0 : Q16_ONE - d;
        end
        if (p > Q16_ONE)
            p = Q16_ONE;
        return p;
    endfunction

    function automatic logic [31:0] mix_pos(logic signed [31:0] b, logic signed [31:0] e,
                                            longint unsigned p);
        longint v;
        v = longint'(p) * longint'(e) + longint'(Q16_ONE - p) * longint'(b);
        v = (v + 64'sd32768) >>> 16;
        return v[31:0];
    endfunction

    function automatic tpi_pkg::rsp_t interpolate_item(tpi_pkg::cmd_t c);
        tpi_pkg::rsp_t   r;
        logic            axis_ok;
        longint unsigned dur, el, t, p;
        r       = '0;
        axis_ok = c.axis < tpi_pkg::AXES;
        p       = 0;
        case (c.kind)
            tpi_pkg::KIND_LOAD:
                if (ph != tpi_pkg::PH_MOTION && axis_ok)
                begin
                    begin_pos[c.axis] = c.position;
                    end_pos[c.axis]   = c.end_position;
                    loaded[c.axis]    = 1'b1;
                    ph                = tpi_pkg::PH_READY;
                    r.accepted        = 1'b1;
                end
            tpi_pkg::KIND_START:
                if (ph == tpi_pkg::PH_READY)
                begin
                    ph         = tpi_pkg::PH_MOTION;
                    t0         = c.time_tick;
                    r.accepted = 1'b1;
                end
            tpi_pkg::KIND_TICK:
            begin
                r.accepted = 1'b1;
                if (ph == tpi_pkg::PH_MOTION)
                begin
                    dur = eff_duration();
                    el  = (c.time_tick >= t0) ? longint'(c.time_tick - t0) : 64'd0;
                    if (el > dur)
                    begin
                        ph = tpi_pkg::PH_DONE;
                        t  = Q16_ONE;
                    end
                    else
                        t = (el << 16) / dur;
                    p = shape_ratio(t);
                end
                if (!axis_ok || ph == tpi_pkg::PH_UNREADY)
                    r.position_out = c.position;
                else if (ph == tpi_pkg::PH_READY)
                    r.position_out = begin_pos[c.axis];
                else if (ph == tpi_pkg::PH_DONE && p == 0)
                    r.position_out = end_pos[c.axis];
                else
                    r.position_out = mix_pos(begin_pos[c.axis], end_pos[c.axis], p);
            end
            default: ;
        endcase
        r.phase = ph;
        return r;
    endfunction

    function automatic int gap_len(int mode);
        int r;
        if (mode == 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < ((mode == 1) ? 70 : 40))
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // never a valid axis that has not been loaded once the block left unready
    function automatic logic [4:0] pick_axis();
        int ax;
        if (ph == tpi_pkg::PH_UNREADY)
            return 5'($urandom_range(0, 31));
        if ($urandom_range(0, 7) == 0)
            return 5'($urandom_range(tpi_pkg::AXES, 31));
        do
            ax = $urandom_range(0, tpi_pkg::AXES - 1);
        while (!loaded[ax]);
        return 5'(ax);
    endfunction

    task automatic push_cmd(logic [1:0] k, logic [4:0] ax, logic [31:0] p, logic [31:0] e,
                            logic [31:0] tt);
        tpi_pkg::cmd_t c;
        c.kind         = k;
        c.axis         = ax;
        c.position     = p;
        c.end_position = e;
        c.time_tick    = tt;
        pending_cmds.push_back(c);
        setpoint_q.push_back(interpolate_item(c));
        items_sent++;
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_valid || setpoint_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tpi_pkg::apb_addr_t'({idx, 2'b00});
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            tpi_pkg::REG_DURATION: cfg_dur = data;
            tpi_pkg::REG_ACCEL:    cfg_acc = data[14:0];
            tpi_pkg::REG_DECEL:    cfg_dec = data[14:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx != REG_UNMAPPED)
        begin
            want = (idx == tpi_pkg::REG_DURATION) ? cfg_dur :
                   (idx == tpi_pkg::REG_ACCEL) ? {17'b0, cfg_acc} : {17'b0, cfg_dec};
            @(negedge clk);
            psel <= 1'b1;
            @(negedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            if (prdata !== want)
            begin
                $error("prdata: expected %h, got %h", want, prdata);
                mismatches++;
            end
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // tick past the end of a running move when the clock allows it
    task automatic close_move();
        longint unsigned el;
        el = eff_duration() + $urandom_range(1, 40);
        if (ph == tpi_pkg::PH_MOTION && longint'(t0) + el <= 64'hFFFF_FFFF)
            push_cmd(tpi_pkg::KIND_TICK, pick_axis(), rand_pos(), rand_pos(),
                     32'(longint'(t0) + el));
    endtask

    task automatic run_move();
        longint unsigned dur, el;
        logic [31:0]     st;
        int              pm;
        close_move();
        repeat (($urandom_range(0, 9) == 0) ? tpi_pkg::AXES : $urandom_range(1, 5))
            push_cmd(tpi_pkg::KIND_LOAD, 5'($urandom_range(0, tpi_pkg::AXES - 1)),
                     rand_pos(), rand_pos(), $urandom);
        if ($urandom_range(0, 2) == 0)
            push_cmd(tpi_pkg::KIND_TICK, pick_axis(), rand_pos(), rand_pos(), $urandom);
        if ($urandom_range(0, 4) == 0)
            push_cmd(tpi_pkg::KIND_LOAD, 5'($urandom_range(tpi_pkg::AXES, 31)), rand_pos(),
                     rand_pos(), $urandom);
        dur = eff_duration();
        st  = (dur > 64'hFFFF_FF00) ? 32'd0 : $urandom_range(0, 32'(64'hFFFF_FFFF - dur - 64));
        push_cmd(tpi_pkg::KIND_START, 5'($urandom_range(0, 31)), rand_pos(), rand_pos(), st);
        pm = 0;
        repeat ($urandom_range(4, 16))
        begin
            case ($urandom_range(0, 19))
                0: push_cmd(tpi_pkg::KIND_LOAD, 5'($urandom_range(0, tpi_pkg::AXES - 1)),
                            rand_pos(), rand_pos(), $urandom);
                1: push_cmd(tpi_pkg::KIND_START, 5'($urandom_range(0, 31)), rand_pos(),
                            rand_pos(), st);
                2: push_cmd(tpi_pkg::KIND_NOP, 5'($urandom_range(0, 31)), rand_pos(),
                            rand_pos(), $urandom);
                3: push_cmd(tpi_pkg::KIND_TICK, pick_axis(), rand_pos(), rand_pos(),
                            st - $urandom_range(1, 1000));
                default:
                begin
                    pm += $urandom_range(0, 150);
                    el = dur * pm / 1000;
                    push_cmd(tpi_pkg::KIND_TICK, pick_axis(), rand_pos(), rand_pos(),
                             32'(longint'(st) + el));
                end
            endcase
        end
        close_move();
        repeat ($urandom_range(0, 3))
            push_cmd(tpi_pkg::KIND_TICK, pick_axis(), rand_pos(), rand_pos(), $urandom);
    endtask

    task automatic shuffle_config();
        case ($urandom_range(0, 9))
            0:       write_reg(tpi_pkg::REG_DURATION, 32'd0);
            1:       write_reg(tpi_pkg::REG_DURATION, $urandom);
            2, 3:    write_reg(tpi_pkg::REG_DURATION, $urandom_range(1, 40));
            4:       ;
            default: write_reg(tpi_pkg::REG_DURATION, $urandom_range(1, 3000));
        endcase
        if ($urandom_range(0, 3) != 0)
            write_reg(tpi_pkg::REG_ACCEL, {17'($urandom_range(0, 131071)),
                                           15'($urandom_range(0, 32767))});
        if ($urandom_range(0, 3) != 0)
            write_reg(tpi_pkg::REG_DECEL, {17'($urandom_range(0, 131071)),
                                           15'($urandom_range(0, 32767))});
        if ($urandom_range(0, 5) == 0)
            write_reg(tpi_pkg::REG_ACCEL, ($urandom_range(0, 1) != 0) ? 32'd32767 : 32'd1);
        if ($urandom_range(0, 5) == 0)
            write_reg(tpi_pkg::REG_DECEL, ($urandom_range(0, 1) != 0) ? 32'd32767 : 32'd0);
    endtask

    // command driver
    always @(negedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (feed_gap > 0)
            begin
                feed_gap--;
                cmd_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0)
            begin
                cmd       <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
                feed_gap   = gap_len(feed_mode);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // response stall
    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                stall_left = gap_len(drain_mode);
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        cmd_taken <= rst_n && cmd_valid && !cmd_stall;
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
        begin
            if (setpoint_q.size() == 0)
            begin
                $error("response transaction with no command outstanding");
                mismatches++;
            end
            else
            begin
                want_rsp = setpoint_q.pop_front();
                if (rsp.position_out !== want_rsp.position_out)
                begin
                    $error("position_out: expected %h, got %h", want_rsp.position_out,
                           rsp.position_out);
                    mismatches++;
                end
                if (rsp.accepted !== want_rsp.accepted)
                begin
                    $error("accepted: expected %b, got %b", want_rsp.accepted, rsp.accepted);
                    mismatches++;
                end
                if (rsp.phase !== want_rsp.phase)
                begin
                    $error("phase: expected %0d, got %0d", want_rsp.phase, rsp.phase);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("trapezoid_profile_interpolator_top test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset configuration
        push_cmd(tpi_pkg::KIND_TICK, 5'd0, 32'h8000_0000, 32'h0, 32'h0);
        push_cmd(tpi_pkg::KIND_TICK, 5'd31, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(tpi_pkg::KIND_START, 5'd0, 32'h0, 32'h0, 32'd0);
        push_cmd(tpi_pkg::KIND_NOP, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd18, 32'h1234_5678, 32'h0, 32'd0);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd31, 32'h0, 32'h7FFF_FFFF, 32'd0);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd17, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd5, 32'h0000_0000, 32'h0100_0000, 32'd0);
        push_cmd(tpi_pkg::KIND_TICK, 5'd5, rand_pos(), rand_pos(), $urandom);
        push_cmd(tpi_pkg::KIND_TICK, 5'd25, rand_pos(), rand_pos(), $urandom);
        push_cmd(tpi_pkg::KIND_START, 5'd0, 32'h0, 32'h0, 32'd1000);
        push_cmd(tpi_pkg::KIND_TICK, 5'd0, rand_pos(), rand_pos(), 32'd500);
        push_cmd(tpi_pkg::KIND_TICK, 5'd17, rand_pos(), rand_pos(), 32'd1000);
        push_cmd(tpi_pkg::KIND_TICK, 5'd5, rand_pos(), rand_pos(), 32'd2000);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd3, rand_pos(), rand_pos(), 32'd0);
        push_cmd(tpi_pkg::KIND_START, 5'd0, 32'h0, 32'h0, 32'd9999);
        push_cmd(tpi_pkg::KIND_TICK, 5'd0, rand_pos(), rand_pos(), 32'd3500);
        push_cmd(tpi_pkg::KIND_TICK, 5'd17, rand_pos(), rand_pos(), 32'd5000);
        push_cmd(tpi_pkg::KIND_TICK, 5'd5, rand_pos(), rand_pos(), 32'd6000);
        push_cmd(tpi_pkg::KIND_TICK, 5'd0, rand_pos(), rand_pos(), 32'd6001);
        push_cmd(tpi_pkg::KIND_TICK, 5'd17, rand_pos(), rand_pos(), 32'd0);
        push_cmd(tpi_pkg::KIND_TICK, 5'd5, rand_pos(), rand_pos(), 32'hFFFF_FFFF);
        push_cmd(tpi_pkg::KIND_START, 5'd0, 32'h0, 32'h0, 32'd7000);
        push_cmd(tpi_pkg::KIND_LOAD, 5'd5, 32'hFF00_0000, 32'h0280_0000, 32'd0);
        drain();

        // zero duration and zero-length segments
        write_reg(tpi_pkg::REG_DURATION, 32'd0);
        write_reg(tpi_pkg::REG_ACCEL, 32'd0);
        write_reg(tpi_pkg::REG_DECEL, 32'd0);
        feed_mode  = 0;
        drain_mode = 0;
        repeat (2) run_move();
        drain();

        // longest move, widest segments, upper bits masked
        write_reg(tpi_pkg::REG_DURATION, 32'hFFFF_FFFF);
        write_reg(tpi_pkg::REG_ACCEL, 32'hFFFF_FFFF);
        write_reg(tpi_pkg::REG_DECEL, 32'h0000_7FFF);
        write_reg(REG_UNMAPPED, $urandom);
        feed_mode  = 2;
        drain_mode = 2;
        repeat (2) run_move();
        drain();

        write_reg(tpi_pkg::REG_DURATION, 32'd1);
        write_reg(tpi_pkg::REG_ACCEL, 32'd1);
        write_reg(tpi_pkg::REG_DECEL, 32'd1);
        feed_mode  = 1;
        drain_mode = 1;
        repeat (2) run_move();

        while (items_sent < 660)
        begin
            drain();
            shuffle_config();
            feed_mode  = $urandom_range(0, 2);
            drain_mode = $urandom_range(0, 2);
            repeat ($urandom_range(3, 6)) run_move();
        end

        drain();
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("trapezoid_profile_interpolator_top test passed");
        else
            $display("trapezoid_profile_interpolator_top test failed");
        $finish;
    end

endmodule

@@ trapezoid_profile_interpolator_top.f @@
sv/tpi_pkg.sv
sv/tpi_ram.sv
sv/tpi_cfg.sv
sv/tpi_div.sv
sv/trapezoid_profile_interpolator_top.sv
dv/trapezoid_profile_interpolator_top_tb.sv
